// File: hw/rtl/i2da_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
`default_nettype none

package i2da_pkg;

    localparam int VALUE_W = 64;
    localparam int DIGITS  = 20;
    localparam int BCD_W   = DIGITS * 4;
    localparam int CNT_W   = $clog2(VALUE_W + 1);
    localparam int DIG_W   = $clog2(DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] DIGIT_FIVE = 4'd5;
    localparam logic [3:0] DIGIT_ADJ  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/i2da_dabble.sv
// One shift-and-add-3 step of the binary to BCD conversion over all digits.
`default_nettype none

module i2da_dabble (
    input  wire logic [i2da_pkg::BCD_W-1:0] i_bcd,
    input  wire logic                       i_bit,
    output logic      [i2da_pkg::BCD_W-1:0] o_bcd
);
    import i2da_pkg::*;

    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[d*4 +: 4] >= DIGIT_FIVE) begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4] + DIGIT_ADJ;
            end else begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4];
            end
        end
    end

    assign o_bcd = {adj[BCD_W-2:0], i_bit};

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_decimal_ascii.sv
// Top level: 64-bit integer to decimal ASCII text, one character per transaction.
//
// Input channel i_valid/o_stall carries i_mode (0 unsigned, 1 signed) and i_value.
// Output channel o_valid/i_stall carries o_character and o_last, one transaction
// per character, most significant digit first, '-' ahead of a negative value.
// A transaction moves on a rising edge with valid high and stall low.
// After a value is taken, o_stall stays high while a shared BCD adjust unit
// runs one step per bit. Leading zero digits are then dropped one per cycle
// (up to 19), and the characters follow one per cycle while the output is not
// stalled. The final character sits in the output register while the next
// value is accepted.
// A stall on the output holds the character register and pauses the sequencer
// at the next character; the conversion steps before it run on.
// Synchronous active-low reset returns to idle with no output pending.
`default_nettype none

module integer_to_decimal_ascii (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_mode,
    input  wire logic [i2da_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [7:0]                   o_character,
    output logic                              o_last
);
    import i2da_pkg::*;

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_mag,   n_mag;
    logic [BCD_W-1:0]   r_bcd,   n_bcd;
    logic [CNT_W-1:0]   r_bits,  n_bits;
    logic [DIG_W-1:0]   r_dig,   n_dig;
    logic               r_neg,   n_neg;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_char,  n_char;
    logic               r_last,  n_last;

    logic [BCD_W-1:0]   step_bcd;
    logic [3:0]         top_digit;
    logic               in_take;
    logic               out_free;

    i2da_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mag[VALUE_W-1]),
        .o_bcd (step_bcd)
    );

    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign in_take   = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_ovalid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_bits   = r_bits;
        n_dig    = r_dig;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && i_stall;
        n_char   = r_char;
        n_last   = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_neg  = i_mode && i_value[VALUE_W-1];
                    n_mag  = n_neg ? (~i_value + VALUE_W'(1)) : i_value;
                    n_bcd  = '0;
                    n_bits = CNT_W'(VALUE_W);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = step_bcd;
                n_mag  = {r_mag[VALUE_W-2:0], 1'b0};
                n_bits = r_bits - CNT_W'(1);
                if (r_bits == CNT_W'(1)) begin
                    n_dig   = DIG_W'(DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && r_dig > DIG_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig = r_dig - DIG_W'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_ZERO + {4'd0, top_digit};
                    n_last   = (r_dig == DIG_W'(1));
                    n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig    = r_dig - DIG_W'(1);
                    if (r_dig == DIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_dig  <= n_dig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: tb/tb_integer_to_decimal_ascii.sv
// Self-checking testbench for the 64-bit integer to decimal ASCII converter.

module tb_integer_to_decimal_ascii;
    import i2da_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_mode  = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [7:0]         o_character;
    logic               o_last;

    char_t       expected_chars[$];
    int unsigned values_sent   = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned cycles        = 0;
    bit          idle_on       = 1'b0;
    bit          hold_req      = 1'b0;

    integer_to_decimal_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycles);
        $display("FAIL integer_to_decimal_ascii");
        $finish;
    end

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Expected text of one value, most significant digit first.
    function automatic void queue_decimal_text(input logic mode, input logic [63:0] value);
        logic [63:0] mag;
        logic [3:0]  digs[$];
        char_t       c;
        bit          neg;
        neg = (mode == MODE_SIGNED) && value[63];
        mag = neg ? (~value + 64'd1) : value;
        do begin
            digs.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        foreach (digs[i]) begin
            c.ch   = CHAR_ZERO + 8'(digs[i]);
            c.last = (i == digs.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %0s", cycles, msg);
    endfunction

    always @(posedge i_clk) begin : check_chars
        char_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected character %0d last %0b",
                                        o_character, o_last));
            end else begin
                want = expected_chars.pop_front();
                if (o_character !== want.ch)
                    flag_mismatch($sformatf("character: expected %0d, got %0d",
                                            want.ch, o_character));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last on char %0d: expected %0b, got %0b",
                                            want.ch, want.last, o_last));
            end
        end
    end

    // Output back-pressure: random bursts, or one long hold on request.
    always begin : out_stall_gen
        int burst;
        @(posedge i_clk);
        if (hold_req) begin
            hold_req = 1'b0;
            i_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            i_stall <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 16);
            i_stall <= 1'b1;
            repeat (burst) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    task automatic send_value(input logic mode, input logic [63:0] value);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        queue_decimal_text(mode, value);
        values_sent++;
    endtask

    // Mix of full-width, short, and decimal-boundary values.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0, 1: ;
            2: v = v >> $urandom_range(1, 63);
            3: begin
                k = $urandom_range(0, 19);
                v = pow10(k) - 64'($urandom_range(0, 1));
            end
            default: begin
                k = $urandom_range(0, 18);
                v = 64'd0 - pow10(k) + 64'($urandom_range(0, 1));
            end
        endcase
        return v;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_value(1'($urandom_range(0, 1)), random_value());
    endtask

    task automatic test_directed();
        send_value(MODE_UNSIGNED, 64'd0);
        send_value(MODE_SIGNED,   64'd0);
        send_value(MODE_UNSIGNED, 64'd1);
        send_value(MODE_SIGNED,   64'd1);
        send_value(MODE_UNSIGNED, 64'd9);
        send_value(MODE_UNSIGNED, 64'd10);
        send_value(MODE_SIGNED,   64'd99);
        send_value(MODE_UNSIGNED, 64'd100);
        send_value(MODE_UNSIGNED, '1);
        send_value(MODE_SIGNED,   '1);
        send_value(MODE_SIGNED,   64'h8000_0000_0000_0000);
        send_value(MODE_UNSIGNED, 64'h8000_0000_0000_0000);
        send_value(MODE_SIGNED,   64'h8000_0000_0000_0001);
        send_value(MODE_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
        send_value(MODE_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
        send_value(MODE_UNSIGNED, pow10(19));
        send_value(MODE_UNSIGNED, pow10(19) - 64'd1);
        send_value(MODE_SIGNED,   pow10(18));
        send_value(MODE_SIGNED,   pow10(18) - 64'd1);
        send_value(MODE_SIGNED,   64'd0 - pow10(18));
        send_value(MODE_SIGNED,   64'd0 - 64'd10);
        send_value(MODE_SIGNED,   64'd0 - 64'd9);
    endtask

    task automatic test_random();
        send_random(280);
    endtask

    // Long output hold while values keep coming: the input must back up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_random(8);
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        send_random(60);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_streaming();

        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0)
            flag_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        $display("converted %0d values in both modes, %0d characters checked, %0d mismatches",
                 values_sent, chars_checked, mismatches);
        $display("covered zero, sign extremes, decimal boundaries and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS integer_to_decimal_ascii");
        else
            $display("FAIL integer_to_decimal_ascii");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/i2da_pkg.sv
hw/rtl/i2da_dabble.sv
hw/rtl/integer_to_decimal_ascii.sv
tb/tb_integer_to_decimal_ascii.sv
